FILE: rtl/bmf_pkg.sv
// Package with shared constants for the box mean filter.
`timescale 1ns / 1ps
`default_nettype none
package bmf_pkg;
  localparam int DefMaxWidth  = 4096;
  localparam int DefMaxWindow = 15;
  localparam int FracBits     = 23;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_WINDOW_WIDTH  = 2'd2,
    REG_WINDOW_HEIGHT = 2'd3
  } reg_index_t;
endpackage
`default_nettype wire

FILE: rtl/bmf_line_mem.sv
// Line store memory holding the last window rows but one of pixels.
`timescale 1ns / 1ps
`default_nettype none
module bmf_line_mem
  import bmf_pkg::*;
#(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [7:0]       rd_data,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [7:0]       wr_data
);
  logic [7:0] mem [Depth];

  // One read port and one write port, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/bmf_col_mem.sv
// Column sum memory with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module bmf_col_mem
  import bmf_pkg::*;
#(
  parameter int Depth = 4096,
  parameter int AddrW = 12,
  parameter int DataW = 13
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [DataW-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [DataW-1:0] wr_data
);
  logic [DataW-1:0] mem [Depth];

  // Dual port memory: a write and a read can happen in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/box_mean_filter_column_sums_core.sv
// Top level of the box mean filter with running column sums.
`timescale 1ns / 1ps
`default_nettype none
// Box mean filter over 8-bit grey pixels in raster order. One pixel item is
// accepted per clock while s_tready is high; each item passes a read stage
// (column sum and line store read), an update stage (column and horizontal
// sums) and a multiply stage, then waits in an output register. A result that
// waits at the output holds the whole pipeline and the input. When the image
// is one pixel wide, consecutive pixels hit the same column, so the column sum
// written in the update stage is forwarded to the next read; the horizontal
// running sum is kept in a register of the update stage. After reset, after a
// configuration write and at each frame end the column store is swept to
// zero, one entry per cycle over the effective image width, while no pixel is
// accepted. After reset or a configuration write the input also waits for the
// reciprocal, which is divided out one bit per cycle, so it stays closed until
// the division ends. Border pixels give no result; results carry the window
// centre and a flag on the last result of a frame.
module box_mean_filter_column_sums_core
  import bmf_pkg::*;
#(
  parameter int MaxWidth  = DefMaxWidth,
  parameter int MaxWindow = DefMaxWindow
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: pixel[7:0]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  // tdata: mean_value[7:0], out_x[19:8], out_y[35:20], zero fill [39:36]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,
  // tuser: frame_last
  output logic             m_tuser,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int XW    = $clog2(MaxWidth);
  localparam int WW    = XW + 1;
  localparam int LineRows = (MaxWindow - 1 > 0) ? MaxWindow - 1 : 1;
  localparam int SlotW = (LineRows > 1) ? $clog2(LineRows) : 1;
  localparam int CapWin = (MaxWindow - 1) / 2 * 2 + 1;
  localparam int CS_W  = 16;
  localparam int HS_W  = 24;
  localparam int LineDepth = LineRows * MaxWidth;
  localparam int LAW   = $clog2(LineDepth);
  localparam int PW    = $clog2(MaxWindow);

  // Configuration registers.
  logic [12:0] image_width;
  logic [15:0] image_height;
  logic [3:0]  window_width, window_height;
  logic        restart;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 13'd640; image_height <= 16'd480;
      window_width <= 4'd3; window_height <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[12:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[3:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[3:0];
        default: ;
      endcase
    end
  end
  assign restart = cfg_we;

  // Effective geometry.
  function automatic logic [4:0] eff_win(input logic [3:0] v);
    logic [4:0] o;
    o = {v[3:1], 1'b1};
    return (o > 5'(CapWin)) ? 5'(CapWin) : o;
  endfunction
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [4:0]    m_eff, n_eff;
  logic [4:0]    k_eff;
  always_comb begin
    if (image_width == 13'd0) w_eff = WW'(1);
    else if (32'(image_width) > MaxWidth) w_eff = WW'(MaxWidth);
    else w_eff = WW'(image_width);
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    m_eff = eff_win(window_width);
    n_eff = eff_win(window_height);
    k_eff = n_eff - 5'd1;
  end

  // Reciprocal floor(2^23 / (m*n)) by restoring division, one quotient bit
  // per cycle, started the cycle after reset or a configuration write.
  logic        div_start, div_busy;
  logic [4:0]  div_cnt;
  logic [9:0]  div_den;
  logic [9:0]  div_rem;
  logic [10:0] div_trial;
  logic [23:0] recip;
  assign div_trial = {div_rem, (div_cnt == 5'd0)};
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      div_start <= 1'b1; div_busy <= 1'b0;
    end else if (div_start) begin
      div_start <= 1'b0; div_busy <= 1'b1;
      div_cnt <= '0; div_rem <= '0;
      div_den <= 10'(m_eff) * 10'(n_eff);
    end else if (div_busy) begin
      if (div_trial >= {1'b0, div_den}) begin
        div_rem <= 10'(div_trial - {1'b0, div_den});
        recip <= {recip[22:0], 1'b1};
      end else begin
        div_rem <= div_trial[9:0];
        recip <= {recip[22:0], 1'b0};
      end
      div_cnt <= div_cnt + 5'd1;
      if (div_cnt == 5'd23) div_busy <= 1'b0;
    end
  end

  // Clearing sweep of the column store.
  logic          clearing;
  logic [WW-1:0] clr_addr;

  // Position counters and the line slot (y mod k) tracked incrementally.
  logic [WW-1:0] col_count;
  logic [15:0]   row_count;
  logic [4:0]    slot;
  logic          accept;
  logic          last;
  logic          out_stall;
  logic          s1_valid, s2_valid, s3_valid;

  assign out_stall = m_tvalid && !m_tready;
  assign s_tready  = !clearing && !restart && !div_start && !div_busy && !out_stall;
  assign accept    = s_tvalid && s_tready;
  assign last = (col_count + WW'(1) >= w_eff) && (32'(row_count) + 1 >= 32'(h_eff));

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      clearing <= 1'b1; clr_addr <= '0;
      col_count <= '0; row_count <= '0; slot <= '0;
    end else if (clearing) begin
      if (clr_addr + WW'(1) >= w_eff) clearing <= 1'b0;
      clr_addr <= clr_addr + WW'(1);
    end else if (accept) begin
      if (last) begin
        col_count <= '0; row_count <= '0; slot <= '0;
        clearing <= 1'b1; clr_addr <= '0;
      end else if (col_count + WW'(1) >= w_eff) begin
        col_count <= '0;
        row_count <= row_count + 16'd1;
        slot <= (slot + 5'd1 >= k_eff) ? 5'd0 : slot + 5'd1;
      end else begin
        col_count <= col_count + WW'(1);
      end
    end
  end

  // Stage 1: read column sum and the old line pixel.
  logic [XW-1:0]  s1_x;
  logic [15:0]    s1_y;
  logic [7:0]     s1_p;
  logic           s1_last, s1_use_old;
  logic [LAW-1:0] s1_laddr;
  logic [LAW-1:0] laddr;
  assign laddr = LAW'(32'(slot) * MaxWidth + 32'(col_count[XW-1:0]));

  logic [CS_W-1:0] cs_rd;
  logic [7:0]      line_rd;
  logic            cs_we;
  logic [XW-1:0]   cs_waddr;
  logic [CS_W-1:0] cs_wdata;
  logic            cs_fwd;
  logic [CS_W-1:0] cs_fwd_data;

  bmf_col_mem #(.Depth(MaxWidth), .AddrW(XW), .DataW(CS_W)) u_col (
    .clk(clk), .rd_en(accept), .rd_addr(col_count[XW-1:0]), .rd_data(cs_rd),
    .wr_en(cs_we), .wr_addr(cs_waddr), .wr_data(cs_wdata));

  logic line_we;
  bmf_line_mem #(.Depth(LineDepth), .AddrW(LAW)) u_line (
    .clk(clk), .rd_en(accept), .rd_addr(laddr), .rd_data(line_rd),
    .wr_en(line_we), .wr_addr(s1_laddr), .wr_data(s1_p));

  // A write to the column being read at the same edge is forwarded.
  always_ff @(posedge clk) begin
    if (rst || restart) s1_valid <= 1'b0;
    else if (!out_stall) s1_valid <= accept;
    if (accept) begin
      s1_x <= col_count[XW-1:0]; s1_y <= row_count; s1_p <= s_tdata;
      s1_last <= last; s1_laddr <= laddr;
      s1_use_old <= (row_count >= 16'(k_eff));
      cs_fwd <= cs_we && (cs_waddr == col_count[XW-1:0]);
      cs_fwd_data <= cs_wdata;
    end
  end

  // Stage 2: column sum update and write-back; horizontal running sum.
  // The last pixel of a frame skips the column sum write-back, the sweep zeroes the store.
  logic [CS_W-1:0] cs_col;
  logic [CS_W-1:0] full;
  logic [CS_W-1:0] win [MaxWindow];
  logic [HS_W-1:0] hsum;
  logic [PW-1:0]   pos;
  logic            s1_go;
  assign s1_go  = s1_valid && !out_stall;
  assign cs_col = cs_fwd ? cs_fwd_data : cs_rd;
  assign full   = (k_eff == 5'd0) ? CS_W'(s1_p) : cs_col + CS_W'(s1_p);
  assign line_we = s1_go && (k_eff != 5'd0);
  always_comb begin
    cs_we = clearing || (s1_go && k_eff != 5'd0 && !s1_last);
    if (clearing) begin
      cs_waddr = clr_addr[XW-1:0]; cs_wdata = '0;
    end else begin
      cs_waddr = s1_x;
      cs_wdata = full - (s1_use_old ? CS_W'(line_rd) : CS_W'(0));
    end
  end

  logic [PW-1:0] pos_ctr;
  assign pos = (s1_x == '0) ? '0 : pos_ctr;
  logic [HS_W-1:0] hsum_base;
  assign hsum_base = (s1_x == '0) ? '0 :
                     hsum - ((32'(s1_x) >= 32'(m_eff)) ? HS_W'(win[pos]) : HS_W'(0));

  logic [HS_W-1:0] s2_sum;
  logic [XW-1:0]   s2_x;
  logic [15:0]     s2_y;
  logic            s2_last, s2_emit;
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s2_valid <= 1'b0; hsum <= '0; pos_ctr <= '0;
    end else if (!out_stall) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        hsum <= hsum_base + HS_W'(full);
        win[pos] <= full;
        pos_ctr <= (5'(pos) + 5'd1 >= m_eff) ? '0 : pos + PW'(1);
        s2_sum <= hsum_base + HS_W'(full);
        s2_x <= s1_x - XW'(m_eff >> 1);
        s2_y <= s1_y - 16'(n_eff >> 1);
        s2_last <= s1_last;
        s2_emit <= (32'(s1_x) + 1 >= 32'(m_eff)) && (32'(s1_y) + 1 >= 32'(n_eff));
      end
    end
  end

  // Stage 3: scale by the reciprocal.
  logic [HS_W+23:0] prod;
  logic [XW-1:0]    s3_x;
  logic [15:0]      s3_y;
  logic             s3_last;
  always_ff @(posedge clk) begin
    if (rst || restart) s3_valid <= 1'b0;
    else if (!out_stall) begin
      s3_valid <= s2_valid && s2_emit;
      prod <= s2_sum * recip;
      s3_x <= s2_x; s3_y <= s2_y; s3_last <= s2_last;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst || restart) m_tvalid <= 1'b0;
    else if (!out_stall) begin
      m_tvalid <= s3_valid;
      m_tdata  <= {4'd0, s3_y, 12'(s3_x), prod[FracBits +: 8]};
      m_tuser  <= s3_last;
    end
  end
endmodule
`default_nettype wire

FILE: verif/box_mean_filter_column_sums_core_tb.sv
// Self-checking testbench for the box mean filter core with running column sums.
`timescale 1ns / 1ps
`default_nettype none
module box_mean_filter_column_sums_core_tb
  import bmf_pkg::*;
();

  localparam int MaxW      = 4096;
  localparam int MaxWin    = 15;
  localparam int LineRows  = MaxWin - 1;
  localparam int CycleCap  = 3000000;
  localparam int DrainWait = 12;

  // Expected filter result.
  typedef struct {
    logic [7:0]  mean_value;
    logic [11:0] out_x;
    logic [15:0] out_y;
    logic        frame_last;
  } mean_result_t;

  // Scoreboard: tracks the filter state and holds the pending means.
  class mean_scoreboard;
    int unsigned img_w, img_h, win_w, win_h;
    int unsigned col, row, hsum, recip;
    int unsigned colsum[MaxW];
    byte unsigned line_rows[LineRows * MaxW];
    int unsigned cwin[MaxWin];
    mean_result_t pending_means[$];
    int errors;

    function int unsigned odd_side(int unsigned v);
      int unsigned o;
      o = (v & 15) / 2 * 2 + 1;
      return (o > MaxWin) ? MaxWin : o;
    endfunction

    function void restart();
      col = 0;
      row = 0;
      hsum = 0;
      foreach (colsum[i]) colsum[i] = 0;
      foreach (cwin[i]) cwin[i] = 0;
      recip = (1 << 23) / (odd_side(win_w) * odd_side(win_h));
    endfunction

    function void reset_state();
      img_w = 640;
      img_h = 480;
      win_w = 3;
      win_h = 3;
      errors = 0;
      foreach (line_rows[i]) line_rows[i] = 0;
      restart();
    endfunction

    function void set_register(reg_index_t idx, logic [15:0] value);
      case (idx)
        REG_IMAGE_WIDTH:   img_w = value & 16'h1FFF;
        REG_IMAGE_HEIGHT:  img_h = value;
        REG_WINDOW_WIDTH:  win_w = value & 16'hF;
        REG_WINDOW_HEIGHT: win_h = value & 16'hF;
        default: ;
      endcase
      restart();
    endfunction

    // Advance the filter by one pixel and queue a mean if a window completes.
    function void note_pixel(logic [7:0] p);
      int unsigned w, h, m, n, k, x, y, full, slot, idx, old;
      bit last;
      mean_result_t r;
      w = (img_w == 0) ? 1 : ((img_w > MaxW) ? MaxW : img_w);
      h = (img_h == 0) ? 1 : img_h;
      m = odd_side(win_w);
      n = odd_side(win_h);
      k = n - 1;
      x = col;
      y = row;
      last = (x + 1 >= w) && (y + 1 >= h);
      if (k == 0) begin
        full = p;
      end else begin
        slot = y % k;
        idx = slot * MaxW + x;
        old = (y >= k) ? line_rows[idx] : 0;
        full = colsum[x] + p;
        colsum[x] = (full - old) & 16'hFFFF;
        line_rows[idx] = p;
      end
      if (x == 0) hsum = 0;
      if (x >= m) hsum -= cwin[x % m];
      hsum += full;
      cwin[x % m] = full & 16'hFFFF;
      if (x + 1 >= m && y + 1 >= n) begin
        r.mean_value = 8'((longint'(hsum) * longint'(recip)) >> 23);
        r.out_x = 12'(x - m / 2);
        r.out_y = 16'(y - n / 2);
        r.frame_last = last;
        pending_means.push_back(r);
      end
      if (last) begin
        restart();
      end else if (col + 1 >= w) begin
        col = 0;
        row = (row + 1) & 16'hFFFF;
      end else begin
        col++;
      end
    endfunction

    // Compare one output item with the oldest pending mean.
    function void check_result(logic [39:0] data, logic user);
      mean_result_t e;
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $time, data, user);
        errors++;
        return;
      end
      e = pending_means.pop_front();
      if (data[7:0] !== e.mean_value) begin
        $display("%0t: mean_value expected %0d actual %0d", $time, e.mean_value, data[7:0]);
        errors++;
      end
      if (data[19:8] !== e.out_x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.out_x, data[19:8]);
        errors++;
      end
      if (data[35:20] !== e.out_y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.out_y, data[35:20]);
        errors++;
      end
      if (data[39:36] !== 4'd0) begin
        $display("%0t: fill expected 0 actual %h", $time, data[39:36]);
        errors++;
      end
      if (user !== e.frame_last) begin
        $display("%0t: frame_last expected %b actual %b", $time, e.frame_last, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  mean_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;

  box_mean_filter_column_sums_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor both handshakes: predict on accepted pixels, check accepted means.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_pixel(s_tdata);
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item was
  // accepted with tvalid still high, so items can follow back to back.
  task automatic send_pixel(input logic [7:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  // Stop offering items, then wait until every expected result has come.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending_means.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] ww, input logic [15:0] wh);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_WIDTH, ww);
    write_reg(REG_WINDOW_HEIGHT, wh);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(8'($urandom_range(255)));
  endtask

  initial begin
    int w, h, n, goal;
    board.reset_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset 3x3 window, then extremes of pixel values.
    send_random(4);
    configure(16'd5, 16'd5, 16'd3, 16'd3);
    // The receiver holds off long enough for the block to fill and stall.
    hold_left = 400;
    for (int i = 0; i < 25; i++) send_pixel((i < 12) ? 8'd255 : 8'd0);
    // Full-range all-white frame with the largest window, then even window sides.
    configure(16'd16, 16'd15, 16'd15, 16'd15);
    for (int i = 0; i < 240; i++) send_pixel(8'd255);
    configure(16'd6, 16'd4, 16'd2, 16'd4);
    send_random(48);
    // Window of one, zero-sized registers and window larger than image.
    configure(16'd0, 16'd0, 16'd0, 16'd0);
    send_random(5);
    configure(16'd3, 16'd3, 16'd9, 16'd1);
    send_random(18);
    // Saturated width register, single-row frame, all-ones height.
    configure(16'h1FFF, 16'd1, 16'd1, 16'd1);
    send_random(40);
    configure(16'd4096, 16'd65535, 16'd14, 16'd3);
    send_random(40);

    // Random phases with the idle schedule in thirds.
    goal = 300;
    n = 0;
    while (n < goal) begin
      if (n < goal / 3) begin
        send_idle_pct = 10; recv_idle_pct = 54;
      end else if (n < 2 * goal / 3) begin
        send_idle_pct = 54; recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      configure(16'(w), 16'(h), 16'($urandom_range(0, (w < 15) ? w : 15)),
                16'($urandom_range(0, (h < 15) ? h : 15)));
      if (n == 0) hold_left = 400;
      for (int f = $urandom_range(1, 2); f > 0; f--) begin
        send_random(w * h);
        n += w * h;
      end
      send_random($urandom_range(0, w));
      if ($urandom_range(3) == 0) wait_drained();
    end

    wait_drained();
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
